// ===== hdl/pngcd_pkg.sv =====
package pngcd_pkg;

	localparam logic [2:0] PH_SIG  = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_TYPE = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_CRC  = 3'd4;
	localparam logic [2:0] PH_END  = 3'd5;
	localparam logic [2:0] PH_ERR  = 3'd6;

	localparam logic [63:0] PNG_SIGNATURE = 64'h8950_4E47_0D0A_1A0A;
	localparam logic [2:0]  SIG_LAST      = 3'd7;
	localparam logic [2:0]  FIELD_LAST    = 3'd3;
	localparam logic [31:0] TYPE_IEND     = 32'h4945_4E44;

	typedef logic [7:0]  byte_t;
	typedef logic [31:0] word_t;

	// Expected signature byte at a position, first byte in the top bits.
	function automatic byte_t sig_byte(input logic [2:0] idx);
		byte_t b;
		unique case (idx)
			3'd0: b = PNG_SIGNATURE[63:56];
			3'd1: b = PNG_SIGNATURE[55:48];
			3'd2: b = PNG_SIGNATURE[47:40];
			3'd3: b = PNG_SIGNATURE[39:32];
			3'd4: b = PNG_SIGNATURE[31:24];
			3'd5: b = PNG_SIGNATURE[23:16];
			3'd6: b = PNG_SIGNATURE[15:8];
			default: b = PNG_SIGNATURE[7:0];
		endcase
		return b;
	endfunction

endpackage

// ===== hdl/png_chunk_deframer.sv =====
// Each byte's result is registered and shown in the cycle after the byte is accepted.
// Throughput: one byte per cycle; the single output register is refilled in the
// same cycle it is drained, so in_ready falls only while a result waits unread.
// Reset (arst_n low, asynchronous): parser returns to the signature phase with
// counters and captured length, type and CRC cleared; no result is pending.
module png_chunk_deframer import pngcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  phase,
	output logic [7:0]  out_byte,
	output logic        is_payload,
	output logic [31:0] chunk_length,
	output logic [31:0] chunk_type,
	output logic [31:0] chunk_crc,
	output logic        header_done,
	output logic        chunk_done,
	output logic        end_seen,
	output logic        sig_error
);

	// Parser state
	logic [2:0] parse_phase_q;
	logic [2:0] field_count_q;
	logic       sig_mismatch_q;
	word_t      length_q;
	word_t      type_q;
	word_t      crc_q;
	word_t      payload_left_q;

	// Result register
	logic       out_valid_q;
	logic [2:0] phase_q;
	byte_t      out_byte_q;
	logic       is_payload_q;
	word_t      chunk_length_q;
	word_t      chunk_type_q;
	word_t      chunk_crc_q;
	logic       header_done_q;
	logic       chunk_done_q;
	logic       end_seen_q;
	logic       sig_error_q;

	logic       in_accept;

	// State as seen by this beat (restart clears it first)
	logic [2:0] cur_phase;
	logic [2:0] cur_count;
	logic       cur_mis;
	word_t      cur_len;
	word_t      cur_type;
	word_t      cur_crc;
	word_t      cur_left;

	logic [2:0] nxt_phase;
	logic [2:0] nxt_count;
	logic       nxt_mis;
	word_t      nxt_len;
	word_t      nxt_type;
	word_t      nxt_crc;
	word_t      nxt_left;
	logic       hdr;
	logic       done;
	logic       pay;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;

	always_comb begin
		if (restart) begin
			cur_phase = PH_SIG;
			cur_count = '0;
			cur_mis   = 1'b0;
			cur_len   = '0;
			cur_type  = '0;
			cur_crc   = '0;
			cur_left  = '0;
		end else begin
			cur_phase = parse_phase_q;
			cur_count = field_count_q;
			cur_mis   = sig_mismatch_q;
			cur_len   = length_q;
			cur_type  = type_q;
			cur_crc   = crc_q;
			cur_left  = payload_left_q;
		end

		nxt_phase = cur_phase;
		nxt_count = cur_count;
		nxt_mis   = cur_mis;
		nxt_len   = cur_len;
		nxt_type  = cur_type;
		nxt_crc   = cur_crc;
		nxt_left  = cur_left;
		hdr       = 1'b0;
		done      = 1'b0;
		pay       = 1'b0;

		unique case (cur_phase)
			PH_SIG: begin
				if (in_byte != sig_byte(cur_count))
					nxt_mis = 1'b1;
				if (cur_count == SIG_LAST) begin
					nxt_count = '0;
					nxt_phase = nxt_mis ? PH_ERR : PH_LEN;
				end else begin
					nxt_count = cur_count + 3'd1;
				end
			end
			PH_LEN: begin
				// The first length byte opens a new chunk and drops the old captures.
				if (cur_count == '0) begin
					nxt_len  = {24'd0, in_byte};
					nxt_type = '0;
					nxt_crc  = '0;
				end else begin
					nxt_len = {cur_len[23:0], in_byte};
				end
				if (cur_count >= FIELD_LAST) begin
					nxt_count = '0;
					nxt_phase = PH_TYPE;
				end else begin
					nxt_count = cur_count + 3'd1;
				end
			end
			PH_TYPE: begin
				nxt_type = {cur_type[23:0], in_byte};
				if (cur_count >= FIELD_LAST) begin
					nxt_count = '0;
					hdr       = 1'b1;
					if (nxt_type == TYPE_IEND) begin
						nxt_phase = PH_END;
					end else if (cur_len == '0) begin
						nxt_phase = PH_CRC;
					end else begin
						nxt_left  = cur_len;
						nxt_phase = PH_DATA;
					end
				end else begin
					nxt_count = cur_count + 3'd1;
				end
			end
			PH_DATA: begin
				pay      = 1'b1;
				nxt_left = cur_left - 32'd1;
				if (nxt_left == '0)
					nxt_phase = PH_CRC;
			end
			PH_CRC: begin
				nxt_crc = {cur_crc[23:0], in_byte};
				if (cur_count >= FIELD_LAST) begin
					nxt_count = '0;
					done      = 1'b1;
					nxt_phase = PH_LEN;
				end else begin
					nxt_count = cur_count + 3'd1;
				end
			end
			default: begin
				// After IEND or a bad signature nothing changes until restart.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_phase_q  <= PH_SIG;
			field_count_q  <= '0;
			sig_mismatch_q <= 1'b0;
			length_q       <= '0;
			type_q         <= '0;
			crc_q          <= '0;
			payload_left_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (in_accept) begin
				parse_phase_q  <= nxt_phase;
				field_count_q  <= nxt_count;
				sig_mismatch_q <= nxt_mis;
				length_q       <= nxt_len;
				type_q         <= nxt_type;
				crc_q          <= nxt_crc;
				payload_left_q <= nxt_left;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			phase_q        <= cur_phase;
			out_byte_q     <= in_byte;
			is_payload_q   <= pay;
			chunk_length_q <= nxt_len;
			chunk_type_q   <= nxt_type;
			chunk_crc_q    <= nxt_crc;
			header_done_q  <= hdr;
			chunk_done_q   <= done;
			end_seen_q     <= (nxt_phase == PH_END);
			sig_error_q    <= nxt_mis;
		end
	end

	assign out_valid    = out_valid_q;
	assign phase        = phase_q;
	assign out_byte     = out_byte_q;
	assign is_payload   = is_payload_q;
	assign chunk_length = chunk_length_q;
	assign chunk_type   = chunk_type_q;
	assign chunk_crc    = chunk_crc_q;
	assign header_done  = header_done_q;
	assign chunk_done   = chunk_done_q;
	assign end_seen     = end_seen_q;
	assign sig_error    = sig_error_q;

	a_pulses_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(header_done_q && chunk_done_q))
		else $error("header and chunk done flagged on the same beat");

	a_payload_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_payload_q) |-> (phase_q == PH_DATA))
		else $error("payload mark outside the payload phase");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && phase_q == PH_ERR) |-> sig_error_q)
		else $error("error phase without signature mismatch");

	a_done_in_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && chunk_done_q) |-> (phase_q == PH_CRC && field_count_q == '0))
		else $error("chunk done outside the last CRC byte");

endmodule

// ===== sim/png_chunk_deframer_checker.sv =====
`timescale 1ns / 100ps

module png_chunk_deframer_checker import pngcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        restart,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  phase,
	input  logic [7:0]  out_byte,
	input  logic        is_payload,
	input  logic [31:0] chunk_length,
	input  logic [31:0] chunk_type,
	input  logic [31:0] chunk_crc,
	input  logic        header_done,
	input  logic        chunk_done,
	input  logic        end_seen,
	input  logic        sig_error,
	output int          fails,
	output int          results_waiting
);

	typedef struct packed {
		logic [2:0] ph;
		byte_t      data;
		logic       payload;
		word_t      length;
		word_t      ctype;
		word_t      crc;
		logic       hdr_done;
		logic       chk_done;
		logic       ended;
		logic       sig_bad;
	} beat_t;

	logic [2:0] ps_phase = PH_SIG;
	logic [2:0] ps_count = '0;
	logic       ps_bad = 1'b0;
	word_t      ps_length = '0;
	word_t      ps_type = '0;
	word_t      ps_crc = '0;
	word_t      ps_left = '0;

	beat_t expected_q[$];

	function automatic void clear_parser();
		ps_phase = PH_SIG;
		ps_count = '0;
		ps_bad = 1'b0;
		ps_length = '0;
		ps_type = '0;
		ps_crc = '0;
		ps_left = '0;
	endfunction

	// Advances the parser by one byte and returns what the block should report for it.
	function automatic beat_t parse_byte(input byte_t b, input logic first);
		beat_t r;
		byte_t want;
		if (first)
			clear_parser();
		r = '0;
		r.ph = ps_phase;
		r.data = b;
		case (ps_phase)
			PH_SIG: begin
				want = PNG_SIGNATURE[63 - 8 * ps_count -: 8];
				if (b != want)
					ps_bad = 1'b1;
				if (ps_count == SIG_LAST) begin
					ps_count = '0;
					ps_phase = ps_bad ? PH_ERR : PH_LEN;
				end else begin
					ps_count = ps_count + 3'd1;
				end
			end
			PH_LEN: begin
				if (ps_count == '0) begin
					ps_length = '0;
					ps_type = '0;
					ps_crc = '0;
				end
				ps_length = {ps_length[23:0], b};
				if (ps_count == FIELD_LAST) begin
					ps_count = '0;
					ps_phase = PH_TYPE;
				end else begin
					ps_count = ps_count + 3'd1;
				end
			end
			PH_TYPE: begin
				ps_type = {ps_type[23:0], b};
				if (ps_count == FIELD_LAST) begin
					ps_count = '0;
					r.hdr_done = 1'b1;
					if (ps_type == TYPE_IEND) begin
						ps_phase = PH_END;
					end else if (ps_length == '0) begin
						ps_phase = PH_CRC;
					end else begin
						ps_left = ps_length;
						ps_phase = PH_DATA;
					end
				end else begin
					ps_count = ps_count + 3'd1;
				end
			end
			PH_DATA: begin
				r.payload = 1'b1;
				ps_left = ps_left - 32'd1;
				if (ps_left == '0)
					ps_phase = PH_CRC;
			end
			PH_CRC: begin
				ps_crc = {ps_crc[23:0], b};
				if (ps_count == FIELD_LAST) begin
					ps_count = '0;
					r.chk_done = 1'b1;
					ps_phase = PH_LEN;
				end else begin
					ps_count = ps_count + 3'd1;
				end
			end
			default: begin
				// After IEND or a bad signature nothing moves until a restart.
			end
		endcase
		r.length = ps_length;
		r.ctype = ps_type;
		r.crc = ps_crc;
		r.ended = (ps_phase == PH_END);
		r.sig_bad = ps_bad;
		return r;
	endfunction

	task automatic check_field(input string name, input word_t want, input word_t got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		beat_t want;
		if (!arst_n) begin
			clear_parser();
			expected_q.delete();
			fails = 0;
			results_waiting <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result with nothing expected: expected none, actual phase %0d byte %h",
						$time, phase, out_byte);
					fails++;
				end else begin
					want = expected_q.pop_front();
					check_field("phase", word_t'(want.ph), word_t'(phase));
					check_field("out_byte", word_t'(want.data), word_t'(out_byte));
					check_field("is_payload", word_t'(want.payload), word_t'(is_payload));
					check_field("chunk_length", want.length, chunk_length);
					check_field("chunk_type", want.ctype, chunk_type);
					check_field("chunk_crc", want.crc, chunk_crc);
					check_field("header_done", word_t'(want.hdr_done), word_t'(header_done));
					check_field("chunk_done", word_t'(want.chk_done), word_t'(chunk_done));
					check_field("end_seen", word_t'(want.ended), word_t'(end_seen));
					check_field("sig_error", word_t'(want.sig_bad), word_t'(sig_error));
				end
			end
			if (in_valid && in_ready)
				expected_q.insert(expected_q.size(), parse_byte(in_byte, restart));
			results_waiting <= expected_q.size();
		end
	end

endmodule

// ===== sim/tb_png_chunk_deframer.sv =====
`timescale 1ns / 100ps

module tb_png_chunk_deframer import pngcd_pkg::*; ;

	localparam int RAND_BYTES  = 750;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	byte_t       in_byte = '0;
	logic        restart = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  phase;
	logic [7:0]  out_byte;
	logic        is_payload;
	logic [31:0] chunk_length;
	logic [31:0] chunk_type;
	logic [31:0] chunk_crc;
	logic        header_done;
	logic        chunk_done;
	logic        end_seen;
	logic        sig_error;

	int   fails;
	int   results_waiting;
	int   src_idle_pct = 0;
	int   sink_stall_pct = 0;
	logic long_stall = 1'b0;
	int   stall_cnt = 0;
	int   quiet = 0;
	int   n_bytes = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	png_chunk_deframer u_dut (.*);

	png_chunk_deframer_checker u_check (.*);

	// Receiver: random stalls, or one long hold-off when asked for.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (long_stall && stall_cnt < HOLD_CYCLES) begin
			out_ready <= 1'b0;
			stall_cnt <= stall_cnt + 1;
		end else begin
			if (!long_stall)
				stall_cnt <= 0;
			out_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic byte_t sig_at(input int idx);
		return PNG_SIGNATURE[63 - 8 * idx -: 8];
	endfunction

	function automatic word_t random_type();
		word_t w;
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(99) < 75)
				w = {w[23:0], byte_t'($urandom_range(0, 1) ? 65 + $urandom_range(25)
					: 97 + $urandom_range(25))};
			else
				w = {w[23:0], byte_t'($urandom)};
		end
		return w;
	endfunction

	task automatic put_byte(input byte_t b, input logic first);
		in_valid <= 1'b1;
		in_byte <= b;
		restart <= first;
		do @(posedge clk); while (!in_ready);
		n_bytes++;
		if ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic put_word(input word_t w);
		for (int i = 3; i >= 0; i--)
			put_byte(w[8 * i +: 8], 1'b0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_waiting != 0);
	endtask

	// One file: signature, a few chunks and usually IEND. Some files carry a bad
	// signature, are cut short, or announce a payload far too long to finish;
	// the restart on the next file cuts those off.
	task automatic make_file();
		int    bad_pos;
		int    cut;
		word_t len;
		bad_pos = ($urandom_range(99) < 12) ? $urandom_range(0, 7) : -1;
		cut = ($urandom_range(99) < 5) ? $urandom_range(1, 7) : 8;
		for (int i = 0; i < cut; i++)
			put_byte((i == bad_pos) ? byte_t'($urandom) : sig_at(i), i == 0);
		if (cut < 8)
			return;
		if (bad_pos >= 0) begin
			repeat ($urandom_range(0, 3)) put_byte(byte_t'($urandom), 1'b0);
			return;
		end
		repeat ($urandom_range(0, 4)) begin
			if ($urandom_range(99) < 8) begin
				put_word($urandom | 32'h0100_0000);
				put_word(random_type());
				repeat ($urandom_range(0, 6)) put_byte(byte_t'($urandom), 1'b0);
				return;
			end
			len = $urandom_range(0, 12);
			put_word(len);
			put_word(random_type());
			repeat (len) put_byte(byte_t'($urandom), 1'b0);
			put_word($urandom);
		end
		if ($urandom_range(99) < 80) begin
			put_word(($urandom_range(99) < 85) ? 32'd0 : $urandom_range(1, 40));
			put_word(TYPE_IEND);
			repeat ($urandom_range(0, 3)) put_byte(byte_t'($urandom), 1'b0);
		end
	endtask

	initial begin
		int start;
		int stage;
		int n_rand;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bad signature at the first byte, extreme byte values, then a held
		// error phase.
		put_byte(8'hFF, 1'b1);
		put_byte(8'h00, 1'b0);
		for (int i = 2; i < 8; i++)
			put_byte(sig_at(i), 1'b0);
		put_byte(sig_at(0), 1'b0);
		// Good signature, then a zero-length IEND and a byte after the end.
		for (int i = 0; i < 8; i++)
			put_byte(sig_at(i), i == 0);
		put_word(32'd0);
		put_word(TYPE_IEND);
		put_byte(8'hFF, 1'b0);

		start = n_bytes;
		stage = -1;
		n_rand = 0;
		while (n_rand < RAND_BYTES) begin
			if (stage != n_rand * 4 / RAND_BYTES) begin
				stage = n_rand * 4 / RAND_BYTES;
				wait_drained();
				case (stage)
					0: begin
						src_idle_pct = 0;
						sink_stall_pct <= 0;
					end
					1: begin
						src_idle_pct = 51;
						sink_stall_pct <= 0;
					end
					2: begin
						src_idle_pct = 0;
						sink_stall_pct <= 51;
					end
					default: begin
						src_idle_pct = 8;
						sink_stall_pct <= 8;
					end
				endcase
				if (stage == 0) begin
					// Keep offering bytes while the output is held so the block backs up.
					long_stall <= 1'b1;
					repeat (3) make_file();
					long_stall <= 1'b0;
				end
			end
			make_file();
			n_rand = n_bytes - start;
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/pngcd_pkg.sv
hdl/png_chunk_deframer.sv
sim/png_chunk_deframer_checker.sv
sim/tb_png_chunk_deframer.sv
